// ===== hdl/dlcw_pkg.sv =====
package dlcw_pkg;

	localparam int STACK_DEPTH     = 16;
	localparam int VERTEX_SLOTS    = 16;
	localparam int TEXTURE_ENTRIES = 64;
	localparam int INDEX_BITS      = 20;

	localparam int SP_BITS   = $clog2(STACK_DEPTH);
	localparam int SL_BITS   = $clog2(STACK_DEPTH + 1);
	localparam int SLOT_BITS = $clog2(VERTEX_SLOTS);
	localparam int TEX_BITS  = $clog2(TEXTURE_ENTRIES);
	localparam int TC_BITS   = $clog2(TEXTURE_ENTRIES + 1);
	localparam int QDEPTH    = 2;

	localparam logic [7:0] OP_VTX      = 8'h04;
	localparam logic [7:0] OP_DL       = 8'h06;
	localparam logic [7:0] OP_END      = 8'hB8;
	localparam logic [7:0] OP_TEXTURE  = 8'hBB;
	localparam logic [7:0] OP_TRI      = 8'hBF;
	localparam logic [7:0] OP_TILESIZE = 8'hF2;
	localparam logic [7:0] OP_SETTILE  = 8'hF5;
	localparam logic [7:0] OP_SETIMG   = 8'hFD;

	localparam logic [2:0] EV_NONE  = 3'd0;
	localparam logic [2:0] EV_TRI   = 3'd1;
	localparam logic [2:0] EV_TEX   = 3'd2;
	localparam logic [2:0] EV_SLOT  = 3'd3;
	localparam logic [2:0] EV_STACK = 3'd4;
	localparam logic [2:0] EV_FULL  = 3'd5;

	typedef enum logic [3:0] {
		K_PLAIN, K_VTX, K_DL, K_END, K_TEXTURE, K_TRI, K_TILESIZE, K_SETTILE, K_SETIMG
	} kind_t;

	// classified command handed from front to back
	typedef struct packed {
		kind_t       kind;
		logic [31:0] addr;
		logic [31:0] low;
		logic [3:0]  vtx_count_m1;
		logic [3:0]  vtx_first;
		logic [4:0]  tri_a;
		logic [4:0]  tri_b;
		logic [4:0]  tri_c;
		logic [10:0] wd;
		logic [10:0] ht;
		logic [4:0]  tkind;
	} cmd_t;

	typedef struct packed {
		logic [31:0] next_address;
		logic        list_done;
		logic [2:0]  event_res;
		logic [20:0] tri_first;
		logic [20:0] tri_second;
		logic [20:0] tri_third;
		logic [31:0] tex_address;
		logic [10:0] tex_width;
		logic [10:0] tex_height;
		logic [2:0]  tex_format;
		logic [1:0]  tex_depth;
	} res_t;

	// byte value divided by ten, 0..25
	function automatic logic [4:0] div10(input logic [7:0] v);
		logic [15:0] p;
		p = 16'(v) * 16'd205;
		return p[15:11];
	endfunction

endpackage

// ===== hdl/dlcw_front.sv =====
module dlcw_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [31:0]         cmd_address,
	input  logic [63:0]         cmd_word,
	output logic                q_valid,
	input  logic                q_ready,
	output dlcw_pkg::cmd_t      q_data
);
	localparam int QB = $clog2(dlcw_pkg::QDEPTH);

	dlcw_pkg::cmd_t       c;
	dlcw_pkg::cmd_t       mem_q [dlcw_pkg::QDEPTH];
	logic [QB-1:0]        wp_q, rp_q;
	logic [QB:0]          cnt_q;
	logic [7:0]           op;
	logic [15:0]          wsrc;
	logic [11:0]          hsrc;

	assign op = cmd_word[63:56];
	assign wsrc = {cmd_word[23:16], cmd_word[15:12], 4'd0};
	assign hsrc = {cmd_word[11:0]};

	always_comb begin
		c = '0;
		c.addr = cmd_address;
		c.low = cmd_word[31:0];
		c.vtx_count_m1 = cmd_word[55:52];
		c.vtx_first = cmd_word[51:48];
		c.tri_a = dlcw_pkg::div10(cmd_word[23:16]);
		c.tri_b = dlcw_pkg::div10(cmd_word[15:8]);
		c.tri_c = dlcw_pkg::div10(cmd_word[7:0]);
		c.wd = 11'(wsrc[15:6] + 10'd0) + 11'd1;
		c.ht = 11'({1'b0, hsrc[11:2]}) + 11'd1;
		c.tkind = {cmd_word[55:53], cmd_word[52:51]};
		case (op)
			dlcw_pkg::OP_VTX:      c.kind = dlcw_pkg::K_VTX;
			dlcw_pkg::OP_DL:       c.kind = dlcw_pkg::K_DL;
			dlcw_pkg::OP_END:      c.kind = dlcw_pkg::K_END;
			dlcw_pkg::OP_TEXTURE:  c.kind = dlcw_pkg::K_TEXTURE;
			dlcw_pkg::OP_TRI:      c.kind = dlcw_pkg::K_TRI;
			dlcw_pkg::OP_TILESIZE: c.kind = dlcw_pkg::K_TILESIZE;
			dlcw_pkg::OP_SETTILE:  c.kind = dlcw_pkg::K_SETTILE;
			dlcw_pkg::OP_SETIMG:   c.kind = dlcw_pkg::K_SETIMG;
			default:               c.kind = dlcw_pkg::K_PLAIN;
		endcase
	end

	assign in_ready = (cnt_q != (QB+1)'(dlcw_pkg::QDEPTH));
	assign q_valid = (cnt_q != '0);
	assign q_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) mem_q[wp_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (in_valid && in_ready) wp_q <= wp_q + 1'b1;
			if (q_valid && q_ready) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QB+1)'(in_valid && in_ready) - (QB+1)'(q_valid && q_ready);
		end
	end
endmodule

// ===== hdl/dlcw_back.sv =====
module dlcw_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [19:0]    index_offset,
	input  logic           q_valid,
	output logic           q_ready,
	input  dlcw_pkg::cmd_t q_data,
	output logic           res_valid,
	input  logic           res_ready,
	output dlcw_pkg::res_t res_q
);
	typedef enum logic [2:0] {ST_IDLE, ST_VTX, ST_POP, ST_SCAN, ST_OUT} state_t;

	localparam int IB = dlcw_pkg::INDEX_BITS;

	state_t                          state_q;
	dlcw_pkg::cmd_t                  cmd_q;
	logic [31:0]                     stack_q [dlcw_pkg::STACK_DEPTH];
	logic [31:0]                     seen_q [dlcw_pkg::TEXTURE_ENTRIES];
	logic [31:0]                     pop_rd_q, seen_rd_q;
	logic [dlcw_pkg::SL_BITS-1:0]    level_q;
	logic [IB-1:0]                   slot_q [dlcw_pkg::VERTEX_SLOTS];
	logic [IB-1:0]                   vcnt_q;
	logic [31:0]                     img_q;
	logic                            img_set_q, dims_set_q;
	logic [10:0]                     wd_q, ht_q;
	logic [4:0]                      tkind_q;
	logic [dlcw_pkg::TC_BITS-1:0]    seen_cnt_q, scan_q;
	logic [4:0]                      vi_q;
	logic                            rd_pend_q;
	logic [4:0]                      vs;
	state_t                          acc_state;
	dlcw_pkg::res_t                  acc_res;

	assign q_ready = (state_q == ST_IDLE) && !res_valid;
	assign vs = 5'(cmd_q.vtx_first) + vi_q;

	// first result and follow-on state for the word at the queue head
	always_comb begin
		acc_res = '0;
		acc_res.next_address = q_data.addr + 32'd8;
		acc_state = ST_OUT;
		case (q_data.kind)
			dlcw_pkg::K_VTX: acc_state = ST_VTX;
			dlcw_pkg::K_DL: begin
				if (level_q >= dlcw_pkg::SL_BITS'(dlcw_pkg::STACK_DEPTH))
					acc_res.event_res = dlcw_pkg::EV_STACK;
				else
					acc_res.next_address = q_data.low;
			end
			dlcw_pkg::K_END: begin
				if (level_q == '0) acc_res.list_done = 1'b1;
				else acc_state = ST_POP;
			end
			dlcw_pkg::K_TRI: begin
				if (q_data.tri_a >= 5'(dlcw_pkg::VERTEX_SLOTS)
						|| q_data.tri_b >= 5'(dlcw_pkg::VERTEX_SLOTS)
						|| q_data.tri_c >= 5'(dlcw_pkg::VERTEX_SLOTS))
					acc_res.event_res = dlcw_pkg::EV_SLOT;
				else begin
					acc_res.event_res = dlcw_pkg::EV_TRI;
					acc_res.tri_first = 21'(slot_q[dlcw_pkg::SLOT_BITS'(q_data.tri_a)])
						+ 21'(index_offset);
					acc_res.tri_second = 21'(slot_q[dlcw_pkg::SLOT_BITS'(q_data.tri_b)])
						+ 21'(index_offset);
					acc_res.tri_third = 21'(slot_q[dlcw_pkg::SLOT_BITS'(q_data.tri_c)])
						+ 21'(index_offset);
				end
			end
			dlcw_pkg::K_TILESIZE: begin
				if (img_set_q) acc_state = ST_SCAN;
			end
			dlcw_pkg::K_SETIMG: begin
				if (dims_set_q) acc_state = ST_SCAN;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		pop_rd_q <= stack_q[dlcw_pkg::SP_BITS'(level_q - 1'b1)];
		seen_rd_q <= seen_q[dlcw_pkg::TEX_BITS'(scan_q)];
		if (state_q == ST_IDLE && q_valid && q_ready && q_data.kind == dlcw_pkg::K_DL
				&& level_q < dlcw_pkg::SL_BITS'(dlcw_pkg::STACK_DEPTH))
			stack_q[dlcw_pkg::SP_BITS'(level_q)] <= q_data.addr;
		if (state_q == ST_SCAN && !rd_pend_q && scan_q == seen_cnt_q
				&& seen_cnt_q < dlcw_pkg::TC_BITS'(dlcw_pkg::TEXTURE_ENTRIES))
			seen_q[dlcw_pkg::TEX_BITS'(seen_cnt_q)] <= img_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			res_valid <= 1'b0;
			res_q <= '0;
			cmd_q <= '0;
			level_q <= '0;
			for (int i = 0; i < dlcw_pkg::VERTEX_SLOTS; i++) slot_q[i] <= '0;
			vcnt_q <= '0;
			img_q <= '1;
			img_set_q <= 1'b0;
			dims_set_q <= 1'b0;
			wd_q <= '0;
			ht_q <= '0;
			tkind_q <= '0;
			seen_cnt_q <= '0;
			scan_q <= '0;
			vi_q <= '0;
			rd_pend_q <= 1'b0;
		end else begin
			if (res_valid && res_ready) res_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (q_valid && q_ready) begin
						cmd_q <= q_data;
						res_q <= acc_res;
						state_q <= acc_state;
						vi_q <= '0;
						scan_q <= '0;
						rd_pend_q <= 1'b1;
						case (q_data.kind)
							dlcw_pkg::K_DL: begin
								if (level_q < dlcw_pkg::SL_BITS'(dlcw_pkg::STACK_DEPTH))
									level_q <= level_q + 1'b1;
							end
							dlcw_pkg::K_TEXTURE: begin
								img_q <= '1;
								img_set_q <= 1'b0;
								wd_q <= '0;
								ht_q <= '0;
								dims_set_q <= 1'b0;
							end
							dlcw_pkg::K_TILESIZE: begin
								wd_q <= q_data.wd;
								ht_q <= q_data.ht;
								dims_set_q <= 1'b1;
							end
							dlcw_pkg::K_SETTILE: tkind_q <= q_data.tkind;
							dlcw_pkg::K_SETIMG: begin
								img_q <= q_data.low;
								img_set_q <= 1'b1;
							end
							default: ;
						endcase
					end
				end
				ST_VTX: begin
					// one slot per cycle
					if (vs < 5'(dlcw_pkg::VERTEX_SLOTS)) begin
						slot_q[dlcw_pkg::SLOT_BITS'(vs)] <= vcnt_q;
						vcnt_q <= vcnt_q + 1'b1;
					end else res_q.event_res <= dlcw_pkg::EV_SLOT;
					vi_q <= vi_q + 1'b1;
					if (vi_q[3:0] == cmd_q.vtx_count_m1) state_q <= ST_OUT;
				end
				ST_POP: begin
					if (rd_pend_q) rd_pend_q <= 1'b0;
					else begin
						level_q <= level_q - 1'b1;
						res_q.next_address <= pop_rd_q + 32'd8;
						state_q <= ST_OUT;
					end
				end
				ST_SCAN: begin
					if (rd_pend_q) rd_pend_q <= 1'b0;
					else if (scan_q == seen_cnt_q) begin
						if (seen_cnt_q >= dlcw_pkg::TC_BITS'(dlcw_pkg::TEXTURE_ENTRIES))
							res_q.event_res <= dlcw_pkg::EV_FULL;
						else begin
							seen_cnt_q <= seen_cnt_q + 1'b1;
							res_q.event_res <= dlcw_pkg::EV_TEX;
							res_q.tex_address <= img_q;
							res_q.tex_width <= wd_q;
							res_q.tex_height <= ht_q;
							res_q.tex_format <= tkind_q[4:2];
							res_q.tex_depth <= tkind_q[1:0];
						end
						state_q <= ST_OUT;
					end else if (seen_rd_q == img_q) state_q <= ST_OUT;
					else begin
						scan_q <= scan_q + 1'b1;
						rd_pend_q <= 1'b1;
					end
				end
				ST_OUT: begin
					res_valid <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== hdl/display_list_command_walker_top.sv =====
// channel | direction | words
// cmd     | in        | cmd_address, cmd_word (in_valid/in_ready)
// cfg     | in        | cfg_data = index_offset (cfg_valid/cfg_ready)
// res     | out       | next_address .. tex_depth (out_valid/out_ready)
// Steps: a vertex load fills its slots in turn, an end that pops reads the return
// stack first, and a texture scan reads the seen-texture table serially.
// Reset: all control clears at once; no clearing pass.
// Stalls: a two-entry queue lets the front take words while the back works;
// the back holds its result until out_ready.
module display_list_command_walker_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] cmd_address,
	input  logic [63:0] cmd_word,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [19:0] cfg_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] next_address,
	output logic        list_done,
	output logic [2:0]  event_res,
	output logic [20:0] tri_first,
	output logic [20:0] tri_second,
	output logic [20:0] tri_third,
	output logic [31:0] tex_address,
	output logic [10:0] tex_width,
	output logic [10:0] tex_height,
	output logic [2:0]  tex_format,
	output logic [1:0]  tex_depth
);
	dlcw_pkg::cmd_t qd;
	dlcw_pkg::res_t r;
	logic           qv, qr;
	logic [19:0]    offset_q;

	// hold the offset register; always take writes
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) offset_q <= 20'd1;
		else if (cfg_valid) offset_q <= cfg_data;
	end

	dlcw_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .cmd_address, .cmd_word,
		.q_valid(qv), .q_ready(qr), .q_data(qd)
	);

	dlcw_back u_back (
		.clk, .arst_n, .index_offset(offset_q), .q_valid(qv), .q_ready(qr), .q_data(qd),
		.res_valid(out_valid), .res_ready(out_ready), .res_q(r)
	);

	assign next_address = r.next_address;
	assign list_done    = r.list_done;
	assign event_res    = r.event_res;
	assign tri_first    = r.tri_first;
	assign tri_second   = r.tri_second;
	assign tri_third    = r.tri_third;
	assign tex_address  = r.tex_address;
	assign tex_width    = r.tex_width;
	assign tex_height   = r.tex_height;
	assign tex_format   = r.tex_format;
	assign tex_depth    = r.tex_depth;
endmodule

// ===== hdl/dlcw_checker.sv =====
module dlcw_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        list_done,
	input logic [2:0]  event_res,
	input logic [20:0] tri_first,
	input logic [10:0] tex_width,
	input logic [31:0] next_address
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(next_address))
		else $error("result dropped while stalled");
	a_ev: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> event_res <= dlcw_pkg::EV_FULL) else $error("bad event code");
	a_tri: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res != dlcw_pkg::EV_TRI |-> tri_first == '0)
		else $error("stray triangle");
	a_tex: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res == dlcw_pkg::EV_TEX |-> tex_width != '0)
		else $error("zero width");
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && list_done |-> event_res == dlcw_pkg::EV_NONE)
		else $error("done with event");
endmodule

bind display_list_command_walker_top dlcw_checker u_chk (
	.clk, .arst_n, .out_valid, .out_ready, .list_done, .event_res, .tri_first,
	.tex_width, .next_address
);

// ===== tb/dlcw_walk_checker.sv =====
module dlcw_walk_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [31:0] cmd_address,
	input  logic [63:0] cmd_word,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [19:0] cfg_data,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] next_address,
	input  logic        list_done,
	input  logic [2:0]  event_res,
	input  logic [20:0] tri_first,
	input  logic [20:0] tri_second,
	input  logic [20:0] tri_third,
	input  logic [31:0] tex_address,
	input  logic [10:0] tex_width,
	input  logic [10:0] tex_height,
	input  logic [2:0]  tex_format,
	input  logic [1:0]  tex_depth,
	output int          errors,
	output int          pending
);

	logic [19:0]                     offset_reg;
	logic [31:0]                     ret_stack [dlcw_pkg::STACK_DEPTH];
	int                              depth;
	logic [dlcw_pkg::INDEX_BITS-1:0] slot_map [dlcw_pkg::VERTEX_SLOTS];
	logic [dlcw_pkg::INDEX_BITS-1:0] vtx_next;
	logic [31:0]                     cur_image;
	logic                            image_valid;
	logic [10:0]                     cur_wd, cur_ht;
	logic                            dims_valid;
	logic [4:0]                      cur_kind;
	logic [31:0]                     known_images [dlcw_pkg::TEXTURE_ENTRIES];
	int                              known_count;
	dlcw_pkg::res_t                  expected_results [$];

	assign pending = expected_results.size();

	task automatic reset_walker();
		offset_reg  = 20'd1;
		depth       = 0;
		vtx_next    = '0;
		cur_image   = '1;
		image_valid = 1'b0;
		cur_wd      = '0;
		cur_ht      = '0;
		dims_valid  = 1'b0;
		cur_kind    = '0;
		known_count = 0;
		foreach (slot_map[i]) slot_map[i] = '0;
	endtask

	// report the current tile if its image address is new
	task automatic note_image(inout dlcw_pkg::res_t r);
		for (int i = 0; i < known_count; i++)
			if (known_images[i] == cur_image) return;
		if (known_count >= dlcw_pkg::TEXTURE_ENTRIES) begin
			r.event_res = dlcw_pkg::EV_FULL;
			return;
		end
		known_images[known_count] = cur_image;
		known_count++;
		r.event_res   = dlcw_pkg::EV_TEX;
		r.tex_address = cur_image;
		r.tex_width   = cur_wd;
		r.tex_height  = cur_ht;
		r.tex_format  = cur_kind[4:2];
		r.tex_depth   = cur_kind[1:0];
	endtask

	task automatic walk_command(input logic [31:0] addr, input logic [63:0] w,
			output dlcw_pkg::res_t r);
		logic [7:0]  b1;
		logic [31:0] wd, ht;
		int          s, a, b, c;
		r = '0;
		r.next_address = addr + 32'd8;
		b1 = w[55:48];
		case (w[63:56])
			dlcw_pkg::OP_VTX: begin
				for (int i = 0; i <= int'(b1[7:4]); i++) begin
					s = int'(b1[3:0]) + i;
					if (s < dlcw_pkg::VERTEX_SLOTS) begin
						slot_map[s] = vtx_next;
						vtx_next = vtx_next + 1'b1;
					end else begin
						r.event_res = dlcw_pkg::EV_SLOT;
					end
				end
			end
			dlcw_pkg::OP_DL: begin
				if (depth >= dlcw_pkg::STACK_DEPTH) begin
					r.event_res = dlcw_pkg::EV_STACK;
				end else begin
					ret_stack[depth] = addr;
					depth++;
					r.next_address = w[31:0];
				end
			end
			dlcw_pkg::OP_END: begin
				if (depth == 0) begin
					r.list_done = 1'b1;
				end else begin
					depth--;
					r.next_address = ret_stack[depth] + 32'd8;
				end
			end
			dlcw_pkg::OP_TEXTURE: begin
				cur_image   = '1;
				image_valid = 1'b0;
				cur_wd      = '0;
				cur_ht      = '0;
				dims_valid  = 1'b0;
			end
			dlcw_pkg::OP_TRI: begin
				a = int'(w[23:16]) / 10;
				b = int'(w[15:8]) / 10;
				c = int'(w[7:0]) / 10;
				if (a >= dlcw_pkg::VERTEX_SLOTS || b >= dlcw_pkg::VERTEX_SLOTS
						|| c >= dlcw_pkg::VERTEX_SLOTS) begin
					r.event_res = dlcw_pkg::EV_SLOT;
				end else begin
					r.event_res  = dlcw_pkg::EV_TRI;
					r.tri_first  = 21'(32'(slot_map[a]) + 32'(offset_reg));
					r.tri_second = 21'(32'(slot_map[b]) + 32'(offset_reg));
					r.tri_third  = 21'(32'(slot_map[c]) + 32'(offset_reg));
				end
			end
			dlcw_pkg::OP_TILESIZE: begin
				wd = (({24'd0, w[23:16]} << 8 | {24'd0, w[15:8] & 8'hF0}) >> 6) + 1;
				ht = (({24'd0, w[15:8] & 8'h0F} << 8 | {24'd0, w[7:0]}) >> 2) + 1;
				cur_wd     = wd[10:0];
				cur_ht     = ht[10:0];
				dims_valid = 1'b1;
				if (image_valid) note_image(r);
			end
			dlcw_pkg::OP_SETTILE: cur_kind = {b1[7:5], b1[4:3]};
			dlcw_pkg::OP_SETIMG: begin
				cur_image   = w[31:0];
				image_valid = 1'b1;
				if (dims_valid) note_image(r);
			end
			default: ;
		endcase
	endtask

	task automatic check_field(input string name, input logic [63:0] exp_v,
			input logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch: expected %0h, got %0h", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		dlcw_pkg::res_t r;
		if (!arst_n) begin
			reset_walker();
			expected_results.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result with nothing expected: next_address %0h",
						$time, next_address);
					errors++;
				end else begin
					r = expected_results.pop_front();
					check_field("next_address", r.next_address, next_address);
					check_field("list_done", r.list_done, list_done);
					check_field("event_res", r.event_res, event_res);
					check_field("tri_first", r.tri_first, tri_first);
					check_field("tri_second", r.tri_second, tri_second);
					check_field("tri_third", r.tri_third, tri_third);
					check_field("tex_address", r.tex_address, tex_address);
					check_field("tex_width", r.tex_width, tex_width);
					check_field("tex_height", r.tex_height, tex_height);
					check_field("tex_format", r.tex_format, tex_format);
					check_field("tex_depth", r.tex_depth, tex_depth);
				end
			end
			if (cfg_valid && cfg_ready) offset_reg = cfg_data;
			if (in_valid && in_ready) begin
				walk_command(cmd_address, cmd_word, r);
				expected_results.push_back(r);
			end
		end
	end

	initial errors = 0;

endmodule

// ===== tb/display_list_command_walker_top_tb.sv =====
module display_list_command_walker_top_tb;

	// generous: the slowest legal run is far below this
	localparam int CYCLE_LIMIT = 1000000;
	// worst result latency: full texture table scan plus margin
	localparam int DRAIN_WAIT  = 200;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] cmd_address;
	logic [63:0] cmd_word;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [19:0] cfg_data;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] next_address;
	logic        list_done;
	logic [2:0]  event_res;
	logic [20:0] tri_first, tri_second, tri_third;
	logic [31:0] tex_address;
	logic [10:0] tex_width, tex_height;
	logic [2:0]  tex_format;
	logic [1:0]  tex_depth;
	int          errors;
	int          pending;
	int          cycles;
	bit          stalls_on;
	int          stall_left;
	logic [31:0] image_pool [8];

	display_list_command_walker_top uut (.*);

	dlcw_walk_checker chk (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// timeout watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// receiver: random stall bursts while stalls are on, else always ready
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready  <= 1'b0;
		end else if (stalls_on && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 13);
			out_ready  <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// present one command word, maybe after a gap, and hold until accepted
	task automatic send_word(input logic [31:0] a, input logic [63:0] w);
		bit taken;
		if (stalls_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		cmd_address <= a;
		cmd_word    <= w;
		do begin
			@(negedge clk);
			taken = in_ready;
			@(posedge clk);
		end while (!taken);
	endtask

	task automatic send_op(input logic [7:0] op, input logic [55:0] body);
		send_word($urandom(), {op, body});
	endtask

	// drain, let any scan finish, then load index_offset
	task automatic load_offset(input logic [19:0] v);
		bit taken;
		in_valid <= 1'b0;
		wait (pending == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end while (!taken);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [55:0] rand_body();
		return 56'({$urandom(), $urandom()});
	endfunction

	// mostly valid slot bytes (below 160), sometimes anything
	function automatic logic [7:0] slot_byte();
		return ($urandom_range(0, 7) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 159));
	endfunction

	function automatic logic [31:0] pick_image();
		int k;
		k = $urandom_range(0, 7);
		if ($urandom_range(0, 2) == 0) return image_pool[k];
		image_pool[k] = $urandom();
		return image_pool[k];
	endfunction

	task automatic random_command();
		logic [55:0] body;
		int          n;
		body = rand_body();
		case ($urandom_range(0, 11))
			0, 1: send_op(dlcw_pkg::OP_VTX, body);
			2, 3: send_op(dlcw_pkg::OP_TRI,
				{body[55:24], slot_byte(), slot_byte(), slot_byte()});
			4: send_op(dlcw_pkg::OP_DL, body);
			5: send_op(dlcw_pkg::OP_END, body);
			6: begin
				// texture setup sequence with random content
				if ($urandom_range(0, 1)) send_op(dlcw_pkg::OP_TEXTURE, body);
				send_op(dlcw_pkg::OP_SETTILE, rand_body());
				send_op(dlcw_pkg::OP_SETIMG, {body[55:32], pick_image()});
				send_op(dlcw_pkg::OP_TILESIZE, rand_body());
			end
			7: send_op(dlcw_pkg::OP_SETIMG, {body[55:32], pick_image()});
			8: send_op(dlcw_pkg::OP_TILESIZE, body);
			9: send_op(dlcw_pkg::OP_SETTILE, body);
			10: begin
				// nest deep, sometimes past the stack, then unwind
				n = $urandom_range(1, dlcw_pkg::STACK_DEPTH + 2);
				repeat (n) send_op(dlcw_pkg::OP_DL, rand_body());
				repeat ($urandom_range(1, n + 1)) send_op(dlcw_pkg::OP_END, rand_body());
			end
			default: send_op(8'($urandom()), body);
		endcase
	endtask

	initial begin
		bit ok;
		cycles      = 0;
		stalls_on   = 1'b1;
		stall_left  = 0;
		in_valid    = 1'b0;
		cmd_address = '0;
		cmd_word    = '0;
		cfg_valid   = 1'b0;
		cfg_data    = '0;
		out_ready   = 1'b0;
		foreach (image_pool[i]) image_pool[i] = $urandom();
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset offset of one, opcode extremes, each special case
		send_word(32'hFFFF_FFF8, 64'h00FF_FFFF_FFFF_FFFF);
		send_word(32'h0, {8'hFF, 56'h0});
		send_op(dlcw_pkg::OP_END, '0);
		send_op(dlcw_pkg::OP_VTX, {8'hF0, 48'h0});
		send_op(dlcw_pkg::OP_VTX, {8'hFF, 48'hFFFF_FFFF_FFFF});
		send_op(dlcw_pkg::OP_TRI, {32'h0, 8'd0, 8'd10, 8'd159});
		send_op(dlcw_pkg::OP_TRI, {32'h0, 8'd160, 8'd0, 8'd255});
		send_op(dlcw_pkg::OP_TILESIZE, {32'h0, 24'hFFFFFF});
		send_op(dlcw_pkg::OP_SETTILE, {8'hFF, 48'h0});
		send_op(dlcw_pkg::OP_SETIMG, {24'h0, 32'hFFFF_FFFF});
		send_op(dlcw_pkg::OP_SETIMG, {24'h0, 32'hFFFF_FFFF});
		send_op(dlcw_pkg::OP_TEXTURE, '0);
		send_op(dlcw_pkg::OP_SETIMG, {24'h0, 32'h0});
		send_op(dlcw_pkg::OP_TILESIZE, '0);
		send_word(32'hFFFF_FFF8, {dlcw_pkg::OP_DL, 24'h0, 32'h0000_1000});
		send_op(dlcw_pkg::OP_END, '0);
		send_op(dlcw_pkg::OP_END, '0);

		load_offset(20'hFFFFF);
		repeat (70) random_command();

		// hold off until every result is back, then fill the texture table
		in_valid <= 1'b0;
		wait (pending == 0);
		@(posedge clk);
		load_offset(20'h00000);
		send_op(dlcw_pkg::OP_TILESIZE, rand_body());
		repeat (dlcw_pkg::TEXTURE_ENTRIES + 4)
			send_op(dlcw_pkg::OP_SETIMG, {24'h0, 32'($urandom())});
		repeat (45) random_command();

		// last part: no idling on either side
		stalls_on = 1'b0;
		load_offset(20'($urandom()));
		repeat (60) random_command();
		in_valid <= 1'b0;

		wait (pending == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		ok = (errors == 0) && (pending == 0);
		if (ok) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
